>>> hw/rtl/sce_pkg.sv
package sce_pkg;

  localparam int SCE_DATA_W      = 32;
  localparam int SCE_CMD_W       = 3;
  localparam int SCE_DEPTH_W     = 5;
  localparam int SCE_STACK_DEPTH = 16;

  typedef enum logic [SCE_CMD_W-1:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_MOD  = 3'd5,
    OP_POP  = 3'd6,
    OP_NOP  = 3'd7
  } sce_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CAPT_B,
    ST_EXEC,
    ST_DIV_WAIT,
    ST_DIV_FIX,
    ST_PUSH,
    ST_FINISH
  } sce_state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture_item;
    logic pop;
    logic capture_b;
    logic exec;
    logic div_fix;
    logic push;
    logic load_out;
  } sce_ctrl_t;

  // datapath -> controller
  typedef struct packed {
    sce_op_t op;
    logic    b_zero;
    logic    div_busy;
  } sce_stat_t;

endpackage

>>> hw/rtl/sce_divider.sv
module sce_divider (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [sce_pkg::SCE_DATA_W-1:0] dividend,
  input  logic [sce_pkg::SCE_DATA_W-1:0] divisor,
  output logic                           busy,
  output logic [sce_pkg::SCE_DATA_W-1:0] quotient,
  output logic [sce_pkg::SCE_DATA_W-1:0] remainder
);
  import sce_pkg::*;

  localparam int StepW = $clog2(SCE_DATA_W);
  localparam logic [StepW-1:0] LastStep = StepW'(SCE_DATA_W - 1);

  logic [SCE_DATA_W-1:0] rem_r, rem_nxt;
  logic [SCE_DATA_W-1:0] quo_r, quo_nxt;
  logic [SCE_DATA_W-1:0] dsr_r;
  logic [StepW-1:0]      step_r;
  logic                  busy_r;
  logic [SCE_DATA_W:0]   trial;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial = {rem_r, quo_r[SCE_DATA_W-1]} - {1'b0, dsr_r};
    if (!trial[SCE_DATA_W]) begin
      rem_nxt = trial[SCE_DATA_W-1:0];
      quo_nxt = {quo_r[SCE_DATA_W-2:0], 1'b1};
    end else begin
      rem_nxt = {rem_r[SCE_DATA_W-2:0], quo_r[SCE_DATA_W-1]};
      quo_nxt = {quo_r[SCE_DATA_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == LastStep) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

>>> hw/rtl/sce_datapath.sv
module sce_datapath #(
  parameter int STACK_DEPTH = sce_pkg::SCE_STACK_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [sce_pkg::SCE_CMD_W-1:0]   in_cmd,
  input  logic [sce_pkg::SCE_DATA_W-1:0]  in_push_value,
  input  sce_pkg::sce_ctrl_t              ctrl,
  output sce_pkg::sce_stat_t              stat,
  output logic [sce_pkg::SCE_DATA_W-1:0]  out_result_value,
  output logic                            out_underflow,
  output logic                            out_overflow,
  output logic                            out_divide_by_zero,
  output logic [sce_pkg::SCE_DEPTH_W-1:0] out_depth
);
  import sce_pkg::*;

  localparam int CntW  = $clog2(STACK_DEPTH + 1);
  localparam int AddrW = $clog2(STACK_DEPTH);
  localparam logic [CntW-1:0] FullCnt = CntW'(STACK_DEPTH);

  logic [SCE_DATA_W-1:0] mem [STACK_DEPTH];

  sce_op_t               op_r;
  logic [SCE_DATA_W-1:0] pv_r;
  logic [CntW-1:0]       count_r;
  logic [SCE_DATA_W-1:0] rd_data_r;
  logic                  hit_r;
  logic [SCE_DATA_W-1:0] b_r;
  logic [SCE_DATA_W-1:0] res_r;
  logic                  under_r;
  logic                  ovf_r;
  logic                  dz_r;
  logic                  neg_a_r;
  logic                  neg_b_r;

  logic [SCE_DATA_W-1:0]   out_res_r;
  logic                    out_under_r;
  logic                    out_ovf_r;
  logic                    out_dz_r;
  logic [SCE_DEPTH_W-1:0]  out_depth_r;

  logic [CntW-1:0]         count_dec;
  logic [AddrW-1:0]        rd_addr;
  logic [SCE_DATA_W-1:0]   pop_val;
  logic [SCE_DATA_W-1:0]   a_val;
  logic [2*SCE_DATA_W-1:0] prod;
  logic [SCE_DATA_W-1:0]   mag_a;
  logic [SCE_DATA_W-1:0]   mag_b;
  logic                    is_div;
  logic                    div_start;
  logic                    div_busy;
  logic [SCE_DATA_W-1:0]   div_q;
  logic [SCE_DATA_W-1:0]   div_rem;
  logic [SCE_DATA_W-1:0]   fix_val;
  logic [SCE_DATA_W-1:0]   push_data;
  logic [CntW+SCE_DEPTH_W-1:0] count_ext;

  always_comb begin
    count_dec = count_r - 1'b1;
    rd_addr   = count_dec[AddrW-1:0];
    pop_val   = hit_r ? rd_data_r : '0;
    a_val     = pop_val;
    prod      = a_val * b_r;
    mag_a     = a_val[SCE_DATA_W-1] ? (SCE_DATA_W'(0) - a_val) : a_val;
    mag_b     = b_r[SCE_DATA_W-1] ? (SCE_DATA_W'(0) - b_r) : b_r;
    is_div    = (op_r == OP_DIV) || (op_r == OP_MOD);
    div_start = ctrl.exec && is_div && (b_r != '0);
    if (op_r == OP_MOD) begin
      fix_val = neg_a_r ? (SCE_DATA_W'(0) - div_rem) : div_rem;
    end else begin
      fix_val = (neg_a_r != neg_b_r) ? (SCE_DATA_W'(0) - div_q) : div_q;
    end
    push_data = (op_r == OP_PUSH) ? pv_r : res_r;
    count_ext = {{SCE_DEPTH_W{1'b0}}, count_r};
  end

  sce_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (mag_a),
    .divisor   (mag_b),
    .busy      (div_busy),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // stack storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctrl.push && (count_r != FullCnt)) begin
      mem[count_r[AddrW-1:0]] <= push_data;
    end
    if (ctrl.pop) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      hit_r   <= 1'b0;
      under_r <= 1'b0;
      ovf_r   <= 1'b0;
      dz_r    <= 1'b0;
      op_r    <= OP_NOP;
    end else begin
      if (ctrl.capture_item) begin
        op_r    <= sce_op_t'(in_cmd);
        under_r <= 1'b0;
        ovf_r   <= 1'b0;
        dz_r    <= 1'b0;
      end
      if (ctrl.pop) begin
        if (count_r != '0) begin
          count_r <= count_dec;
          hit_r   <= 1'b1;
        end else begin
          hit_r   <= 1'b0;
          under_r <= 1'b1;
        end
      end
      if (ctrl.exec && is_div && (b_r == '0)) begin
        dz_r <= 1'b1;
      end
      if (ctrl.push) begin
        if (count_r == FullCnt) begin
          ovf_r <= 1'b1;
        end else begin
          count_r <= count_r + 1'b1;
        end
      end
    end
  end

  // operands and result
  always_ff @(posedge clk) begin
    if (ctrl.capture_item) begin
      pv_r  <= in_push_value;
      res_r <= '0;
    end
    if (ctrl.capture_b) begin
      b_r <= pop_val;
    end
    if (ctrl.exec) begin
      neg_a_r <= a_val[SCE_DATA_W-1];
      neg_b_r <= b_r[SCE_DATA_W-1];
      unique case (op_r)
        OP_ADD:  res_r <= a_val + b_r;
        OP_SUB:  res_r <= a_val - b_r;
        OP_MUL:  res_r <= prod[SCE_DATA_W-1:0];
        OP_POP:  res_r <= b_r;
        default: res_r <= '0;
      endcase
    end
    if (ctrl.div_fix) begin
      res_r <= fix_val;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      out_res_r   <= res_r;
      out_under_r <= under_r;
      out_ovf_r   <= ovf_r;
      out_dz_r    <= dz_r;
      out_depth_r <= count_ext[SCE_DEPTH_W-1:0];
    end
  end

  assign stat.op       = op_r;
  assign stat.b_zero   = (b_r == '0);
  assign stat.div_busy = div_busy;

  assign out_result_value   = out_res_r;
  assign out_underflow      = out_under_r;
  assign out_overflow       = out_ovf_r;
  assign out_divide_by_zero = out_dz_r;
  assign out_depth          = out_depth_r;

endmodule

>>> hw/rtl/sce_ctrl.sv
module sce_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  sce_pkg::sce_stat_t stat,
  output sce_pkg::sce_ctrl_t ctrl
);
  import sce_pkg::*;

  sce_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        priority if (stat.op == OP_PUSH) state_nxt = ST_PUSH;
        else if (stat.op == OP_NOP)      state_nxt = ST_FINISH;
        else                             state_nxt = ST_CAPT_B;
      end
      ST_CAPT_B: state_nxt = ST_EXEC;
      ST_EXEC: begin
        priority if (stat.op == OP_POP) begin
          state_nxt = ST_FINISH;
        end else if (stat.op == OP_DIV || stat.op == OP_MOD) begin
          state_nxt = stat.b_zero ? ST_FINISH : ST_DIV_WAIT;
        end else begin
          state_nxt = ST_PUSH;
        end
      end
      ST_DIV_WAIT: begin
        if (!stat.div_busy) state_nxt = ST_DIV_FIX;
      end
      ST_DIV_FIX: state_nxt = ST_PUSH;
      ST_PUSH:    state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state_r)
      ST_IDLE:     ctrl.capture_item = in_valid;
      ST_DECODE:   ctrl.pop = (stat.op != OP_PUSH) && (stat.op != OP_NOP);
      ST_CAPT_B: begin
        ctrl.capture_b = 1'b1;
        // operators take a second operand
        ctrl.pop       = (stat.op != OP_POP);
      end
      ST_EXEC:     ctrl.exec = 1'b1;
      ST_DIV_WAIT: ctrl = '0;
      ST_DIV_FIX:  ctrl.div_fix = 1'b1;
      ST_PUSH:     ctrl.push = 1'b1;
      ST_FINISH:   ctrl.load_out = slot_free;
      default:     ctrl = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (ctrl.load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the input off while reset is applied
  assign in_stall  = !rst_n || (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/stack_calculator_engine.sv
// Sequence per item: a no-op goes straight to finish; a push writes the stack, then finishes;
//   pop, and divide or modulo by zero, pop operands, execute and finish; add/sub/mul also push;
//   divide and modulo wait on the one-bit-per-cycle shared divider, fix the sign and push.
// One item at a time: the next item is taken the cycle after the result is loaded.
// Reset (rst_n low, synchronous): stack empty, no result pending, input stalled.
module stack_calculator_engine #(
  parameter int STACK_DEPTH = sce_pkg::SCE_STACK_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sce_pkg::SCE_CMD_W-1:0]   in_cmd,
  input  logic [sce_pkg::SCE_DATA_W-1:0]  in_push_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sce_pkg::SCE_DATA_W-1:0]  out_result_value,
  output logic                            out_underflow,
  output logic                            out_overflow,
  output logic                            out_divide_by_zero,
  output logic [sce_pkg::SCE_DEPTH_W-1:0] out_depth
);
  import sce_pkg::*;

  sce_ctrl_t ctrl;
  sce_stat_t stat;

  sce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  sce_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_cmd             (in_cmd),
    .in_push_value      (in_push_value),
    .ctrl               (ctrl),
    .stat               (stat),
    .out_result_value   (out_result_value),
    .out_underflow      (out_underflow),
    .out_overflow       (out_overflow),
    .out_divide_by_zero (out_divide_by_zero),
    .out_depth          (out_depth)
  );

endmodule

>>> sim/stack_calc_checker.sv
`timescale 1ns / 1ps

module stack_calc_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [sce_pkg::SCE_CMD_W-1:0]   in_cmd,
  input  logic [sce_pkg::SCE_DATA_W-1:0]  in_push_value,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [sce_pkg::SCE_DATA_W-1:0]  out_result_value,
  input  logic                            out_underflow,
  input  logic                            out_overflow,
  input  logic                            out_divide_by_zero,
  input  logic [sce_pkg::SCE_DEPTH_W-1:0] out_depth,
  output int                              mismatch_count,
  output int                              pending_count
);
  import sce_pkg::*;

  typedef struct packed {
    logic [SCE_DATA_W-1:0]  value;
    logic                   underflow;
    logic                   overflow;
    logic                   div_zero;
    logic [SCE_DEPTH_W-1:0] depth;
  } calc_result_t;

  calc_result_t          pending_results[$];
  logic [SCE_DATA_W-1:0] stack_mem[SCE_STACK_DEPTH];
  int unsigned           stack_cnt;
  logic                  pop_empty;

  initial pending_count = 0;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: result %s mismatch: got %h, want %h", $time, field, got, want);
    mismatch_count++;
  endtask

  // An empty stack yields 0 and flags the pop.
  function automatic logic [SCE_DATA_W-1:0] take_top();
    if (stack_cnt == 0) begin
      pop_empty = 1'b1;
      return '0;
    end
    stack_cnt--;
    return stack_mem[stack_cnt];
  endfunction

  function automatic logic store_top(input logic [SCE_DATA_W-1:0] v);
    if (stack_cnt >= SCE_STACK_DEPTH) return 1'b0;
    stack_mem[stack_cnt] = v;
    stack_cnt++;
    return 1'b1;
  endfunction

  // Truncate toward zero; the remainder follows the dividend's sign.
  function automatic logic [SCE_DATA_W-1:0] signed_divide(input logic [SCE_DATA_W-1:0] a,
                                                          input logic [SCE_DATA_W-1:0] b,
                                                          input logic want_rem);
    logic [SCE_DATA_W-1:0] ma, mb, q, r;
    ma = a[SCE_DATA_W-1] ? -a : a;
    mb = b[SCE_DATA_W-1] ? -b : b;
    q  = ma / mb;
    r  = ma % mb;
    if (want_rem) return a[SCE_DATA_W-1] ? -r : r;
    return (a[SCE_DATA_W-1] ^ b[SCE_DATA_W-1]) ? -q : q;
  endfunction

  task automatic apply_command(input sce_op_t op, input logic [SCE_DATA_W-1:0] val);
    calc_result_t          r;
    logic [SCE_DATA_W-1:0] lhs, rhs;
    r = '0;
    pop_empty = 1'b0;
    case (op)
      OP_PUSH: begin
        r.overflow = !store_top(val);
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
        rhs = take_top();
        lhs = take_top();
        case (op)
          OP_ADD: r.value = lhs + rhs;
          OP_SUB: r.value = lhs - rhs;
          OP_MUL: r.value = lhs * rhs;
          default: begin
            if (rhs == '0) r.div_zero = 1'b1;
            else r.value = signed_divide(lhs, rhs, op == OP_MOD);
          end
        endcase
        if (!r.div_zero) void'(store_top(r.value));
      end
      OP_POP: begin
        r.value = take_top();
      end
      default: ;
    endcase
    r.underflow = pop_empty;
    r.depth     = SCE_DEPTH_W'(stack_cnt);
    pending_results.push_back(r);
  endtask

  always @(posedge clk) begin
    calc_result_t want;
    if (!rst_n) begin
      stack_cnt = 0;
      pending_results.delete();
    end else begin
      // Check the result beat first; it can never belong to a beat accepted at this edge.
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("beat with none pending", out_result_value, '0);
        end else begin
          want = pending_results.pop_front();
          if (out_result_value !== want.value)
            report_mismatch("value", out_result_value, want.value);
          if (out_underflow !== want.underflow)
            report_mismatch("underflow", 32'(out_underflow), 32'(want.underflow));
          if (out_overflow !== want.overflow)
            report_mismatch("overflow", 32'(out_overflow), 32'(want.overflow));
          if (out_divide_by_zero !== want.div_zero)
            report_mismatch("divide_by_zero", 32'(out_divide_by_zero), 32'(want.div_zero));
          if (out_depth !== want.depth)
            report_mismatch("depth", 32'(out_depth), 32'(want.depth));
        end
      end
      if (in_valid && !in_stall) apply_command(sce_op_t'(in_cmd), in_push_value);
    end
    pending_count <= pending_results.size();
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sce_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [SCE_CMD_W-1:0]   in_cmd;
  logic [SCE_DATA_W-1:0]  in_push_value;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [SCE_DATA_W-1:0]  out_result_value;
  logic                   out_underflow;
  logic                   out_overflow;
  logic                   out_divide_by_zero;
  logic [SCE_DEPTH_W-1:0] out_depth;

  int fail_count;
  int pending_count;
  int gap_pct   = 0;
  int stall_pct = 0;

  stack_calculator_engine dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_push_value      (in_push_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_value   (out_result_value),
    .out_underflow      (out_underflow),
    .out_overflow       (out_overflow),
    .out_divide_by_zero (out_divide_by_zero),
    .out_depth          (out_depth)
  );

  stack_calc_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_push_value      (in_push_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_value   (out_result_value),
    .out_underflow      (out_underflow),
    .out_overflow       (out_overflow),
    .out_divide_by_zero (out_divide_by_zero),
    .out_depth          (out_depth),
    .mismatch_count     (fail_count),
    .pending_count      (pending_count)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Hold the beat until it is taken; leave valid high for the next call.
  task automatic send_beat(input sce_op_t op, input logic [SCE_DATA_W-1:0] val);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < gap_pct) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= op;
    in_push_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Small values make zero divisors common; extremes exercise wrapping.
  function automatic logic [SCE_DATA_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 30) return $urandom_range(8) - 4;
    if (sel < 45) begin
      case ($urandom_range(3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return '1;
        default: return '0;
      endcase
    end
    return $urandom();
  endfunction

  // Filling runs drive the stack to full; draining runs empty it.
  function automatic sce_op_t pick_op(input bit filling);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < (filling ? 65 : 25)) return OP_PUSH;
    if (sel < 90) return sce_op_t'(3'($urandom_range(5, 1)));
    if (sel < 96) return OP_POP;
    return OP_NOP;
  endfunction

  task automatic run_random(input int beats);
    bit filling;
    for (int i = 0; i < beats; i++) begin
      if (i % 20 == 0) filling = 1'($urandom_range(1));
      send_beat(pick_op(filling), pick_value());
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_cmd        = OP_NOP;
    in_push_value = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty-stack underflow: pop, then an operator with both operands missing.
    send_beat(OP_POP, '0);
    send_beat(OP_SUB, 32'hffff_ffff);
    send_beat(OP_PUSH, 32'h7fff_ffff);
    send_beat(OP_PUSH, 32'ha5a5_a5a5);
    for (int i = 0; i < 6; i++) send_beat(OP_PUSH, $urandom());
    send_beat(OP_PUSH, 32'd100);
    send_beat(OP_PUSH, 32'd5);
    send_beat(OP_PUSH, -32'sd7);
    send_beat(OP_PUSH, 32'd2);
    send_beat(OP_PUSH, '1);
    send_beat(OP_PUSH, 32'h8000_0000);
    send_beat(OP_PUSH, '1);
    // Stack is full: drop this one.
    send_beat(OP_PUSH, 32'h1234_5678);
    send_beat(OP_DIV, '0);
    send_beat(OP_ADD, '0);
    send_beat(OP_MUL, '0);
    send_beat(OP_MOD, '0);
    send_beat(OP_SUB, '0);
    send_beat(OP_PUSH, '0);
    send_beat(OP_MOD, '0);
    send_beat(OP_PUSH, '0);
    send_beat(OP_DIV, '0);
    send_beat(OP_POP, 32'hffff_ffff);
    send_beat(OP_NOP, 32'h5a5a_5a5a);

    gap_pct   = 8;
    stall_pct = 86;
    run_random(134);
    gap_pct   = 86;
    stall_pct = 8;
    run_random(134);
    gap_pct   = 0;
    stall_pct = 0;
    run_random(134);
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/sce_pkg.sv
hw/rtl/sce_divider.sv
hw/rtl/sce_datapath.sv
hw/rtl/sce_ctrl.sv
hw/rtl/stack_calculator_engine.sv
sim/stack_calc_checker.sv
sim/tb_top.sv
